// ===== rtl/kcs_pkg.sv =====
// kcs_pkg: shared types and codes for the kcs host transaction engine
// used by kcs_rsp_fifo and kcs_host_transaction_engine, no dependencies
package kcs_pkg;

    // request kinds on the input channel
    localparam logic [2:0] REQ_START   = 3'd0;
    localparam logic [2:0] REQ_PAYLOAD = 3'd1;
    localparam logic [2:0] REQ_STATUS  = 3'd2;
    localparam logic [2:0] REQ_DATA    = 3'd3;
    localparam logic [2:0] REQ_TICK    = 3'd4;

    // bus operation codes on the result channel
    localparam logic [2:0] OP_RD_STATUS = 3'd0;
    localparam logic [2:0] OP_RD_DATA   = 3'd1;
    localparam logic [2:0] OP_WR_DATA   = 3'd2;
    localparam logic [2:0] OP_WR_CMD    = 3'd3;
    localparam logic [2:0] OP_REPLY     = 3'd4;
    localparam logic [2:0] OP_FINISHED  = 3'd5;

    // transaction outcomes
    localparam logic [2:0] OC_OK           = 3'd0;
    localparam logic [2:0] OC_SEND_FAIL    = 3'd1;
    localparam logic [2:0] OC_IBF_TIMEOUT  = 3'd2;
    localparam logic [2:0] OC_WRONG_STATE  = 3'd3;
    localparam logic [2:0] OC_READ_TIMEOUT = 3'd4;

    // kcs control codes and states
    localparam logic [7:0] KCS_START_WRITE = 8'h61;
    localparam logic [7:0] KCS_END_WRITE   = 8'h62;
    localparam logic [7:0] KCS_READ_BYTE   = 8'h68;
    localparam logic [1:0] KST_IDLE        = 2'd0;
    localparam logic [1:0] KST_READ        = 2'd1;
    localparam logic [1:0] KST_WRITE       = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PORT_BASE = 2'd0;
    localparam logic [1:0] CFG_SPACING   = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd2;

    // width used for length compares (holds a count of 256)
    localparam int CW = 9;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [7:0]  value;
        logic [7:0]  count;
        logic [2:0]  outcome;
        logic        last;
    } kcs_res_t;

endpackage

// ===== rtl/kcs_rsp_fifo.sv =====
// kcs_rsp_fifo: four-entry result queue, takes up to two items a cycle
// depends on kcs_pkg for the result item type
module kcs_rsp_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_cnt,
    input  kcs_pkg::kcs_res_t push0,
    input  kcs_pkg::kcs_res_t push1,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output kcs_pkg::kcs_res_t out_res
);

    kcs_pkg::kcs_res_t fifo_mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign out_valid = (cnt_reg != 3'd0);
    assign out_res   = fifo_mem[rd_ptr_reg];
    assign room      = (cnt_reg <= 3'd2);
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        cnt_next    = cnt_reg + {1'b0, push_cnt} - {2'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            fifo_mem[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            fifo_mem[wr_ptr_reg + 2'd1] <= push1;
        end
    end

endmodule

// ===== rtl/kcs_host_transaction_engine.sv =====
// kcs_host_transaction_engine: host side kcs transfer sequencer with payload buffer
// depends on kcs_pkg and kcs_rsp_fifo
//
//  channel | direction | handshake        | content
//  s_      | in        | s_valid/s_ready  | start, payload byte, status, data return, tick
//  m_      | out       | m_valid/m_ready  | port accesses, reply bytes, finish
//  cfg_    | in        | cfg_wr_en        | port_base, register_spacing, timeout_ms
//
// one item per cycle: each item is handled in the cycle it is accepted and pushes
// up to two results into a four-entry queue; s_ready drops while the queue has
// fewer than two free entries, so a stalled m_ side stops intake once three or
// more results are held.
// the payload buffer is a one-port-write memory read every cycle at the address
// the next state will need, with bypass of a same-cycle write; it needs no clearing.
// synchronous active-low reset returns to idle with the register defaults.
module kcs_host_transaction_engine #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [5:0]  s_netfn,
    input  logic [1:0]  s_lun,
    input  logic [7:0]  s_command_code,
    input  logic [7:0]  s_payload_count,
    input  logic [7:0]  s_reply_capacity,
    input  logic [7:0]  s_payload_byte,
    input  logic [7:0]  s_status_value,
    input  logic [7:0]  s_read_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_bus_op,
    output logic [15:0] m_bus_address,
    output logic [7:0]  m_bus_value,
    output logic [7:0]  m_reply_count,
    output logic [2:0]  m_outcome,
    output logic        m_last
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LW = $clog2(MAX_PAYLOAD + 1);
    localparam int CW = kcs_pkg::CW;

    typedef enum logic [4:0] {
        PH_IDLE, PH_LOAD,
        PH_C_W1, PH_C_S1, PH_C_D1, PH_C_W2, PH_C_S2, PH_C_D2,
        PH_D_W, PH_D_S1, PH_D_S2, PH_D_D,
        PH_L_W, PH_L_S1, PH_L_S2, PH_L_D,
        PH_R_W0, PH_R_S, PH_R_WO, PH_R_D, PH_R_WI
    } phase_t;

    typedef enum logic [2:0] {
        ST_START, ST_HEADER, ST_BODY, ST_END, ST_LAST, ST_READ
    } stage_t;

    logic [15:0] port_base_reg, timeout_reg;
    logic [4:0]  spacing_reg;

    phase_t      phase_reg, phase_next;
    stage_t      stage_reg, stage_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] loaded_reg, loaded_next;
    logic [7:0]  si_reg, si_next;
    logic [7:0]  header_reg, header_next;
    logic [7:0]  command_reg, command_next;
    logic [15:0] timer_reg, timer_next;
    logic [7:0]  kept_reg, kept_next;
    logic [7:0]  limit_reg, limit_next;

    logic [7:0]  payload_mem [MAX_PAYLOAD];
    logic [7:0]  rd_data_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic        mem_we;

    logic        s_acc;
    logic        room;
    logic [1:0]  n_emit;
    kcs_pkg::kcs_res_t res_v [2];
    kcs_pkg::kcs_res_t out_res;

    logic [15:0] data_addr, cmd_addr;
    logic        do_cmd, do_unit, do_last, wait_ok;
    logic        obf, ibf, bad;
    logic [1:0]  kst;
    logic [CW-1:0] clamp_len, len_m1;
    logic [7:0]  si_inc;

    assign s_acc     = s_valid && s_ready;
    assign s_ready   = room;
    assign data_addr = port_base_reg;
    assign cmd_addr  = port_base_reg + {11'b0, spacing_reg};
    assign obf       = s_status_value[0];
    assign ibf       = s_status_value[1];
    assign kst       = s_status_value[7:6];
    assign bad       = obf && (kst != kcs_pkg::KST_WRITE);
    assign wr_addr   = loaded_reg[AW-1:0];
    assign si_inc    = si_reg + 8'd1;

    function automatic kcs_pkg::kcs_res_t mk(input logic [2:0] op, input logic [15:0] addr,
                                             input logic [7:0] value, input logic [7:0] cnt,
                                             input logic [2:0] oc);
        kcs_pkg::kcs_res_t r;
        r.op      = op;
        r.addr    = addr;
        r.value   = value;
        r.count   = cnt;
        r.outcome = oc;
        r.last    = 1'b0;
        return r;
    endfunction

    always_comb begin
        phase_next   = phase_reg;
        stage_next   = stage_reg;
        len_next     = len_reg;
        loaded_next  = loaded_reg;
        si_next      = si_reg;
        header_next  = header_reg;
        command_next = command_reg;
        timer_next   = timer_reg;
        kept_next    = kept_reg;
        limit_next   = limit_reg;
        mem_we       = 1'b0;
        do_cmd       = 1'b0;
        do_unit      = 1'b0;
        do_last      = 1'b0;
        n_emit       = 2'd0;
        res_v[0]     = '0;
        res_v[1]     = '0;
        wait_ok      = 1'b0;
        clamp_len    = ({1'b0, s_payload_count} > CW'(MAX_PAYLOAD)) ? CW'(MAX_PAYLOAD)
                                                                    : {1'b0, s_payload_count};
        if (s_acc) begin
            unique case (s_req_type)
                kcs_pkg::REQ_START: begin
                    if (phase_reg == PH_IDLE) begin
                        header_next  = {s_netfn, s_lun};
                        command_next = s_command_code;
                        len_next     = clamp_len[LW-1:0];
                        loaded_next  = '0;
                        si_next      = '0;
                        limit_next   = s_reply_capacity;
                        kept_next    = '0;
                        if (clamp_len == '0) begin
                            stage_next = ST_START;
                            timer_next = '0;
                            res_v[n_emit[0]] = mk(kcs_pkg::OP_RD_STATUS, cmd_addr, 8'd0,
                                                  kept_next, kcs_pkg::OC_OK);
                            n_emit = n_emit + 2'd1;
                            phase_next = PH_C_W1;
                        end else begin
                            phase_next = PH_LOAD;
                        end
                    end
                end
                kcs_pkg::REQ_PAYLOAD: begin
                    if (phase_reg == PH_LOAD) begin
                        mem_we      = 1'b1;
                        loaded_next = loaded_reg + LW'(1);
                        if (CW'(loaded_reg) + CW'(1) >= CW'(len_reg)) begin
                            stage_next = ST_START;
                            timer_next = '0;
                            res_v[n_emit[0]] = mk(kcs_pkg::OP_RD_STATUS, cmd_addr, 8'd0,
                                                  kept_next, kcs_pkg::OC_OK);
                            n_emit = n_emit + 2'd1;
                            phase_next = PH_C_W1;
                        end
                    end
                end
                kcs_pkg::REQ_STATUS: begin
                    unique case (phase_reg)
                        PH_C_W1, PH_C_W2, PH_D_W, PH_L_W, PH_R_W0, PH_R_WO, PH_R_WI: begin
                            wait_ok = (phase_reg == PH_R_WO) ? obf : !ibf;
                            if (wait_ok) begin
                                unique case (phase_reg)
                                    PH_R_WO: begin
                                        if (kept_reg < limit_reg) begin
                                            res_v[n_emit[0]] = mk(kcs_pkg::OP_RD_DATA,
                                                data_addr, 8'd0, kept_next, kcs_pkg::OC_OK);
                                            n_emit = n_emit + 2'd1;
                                            phase_next = PH_R_D;
                                        end else begin
                                            timer_next = '0;
                                            res_v[n_emit[0]] = mk(kcs_pkg::OP_RD_STATUS,
                                                cmd_addr, 8'd0, kept_next, kcs_pkg::OC_OK);
                                            n_emit = n_emit + 2'd1;
                                            phase_next = PH_R_WI;
                                        end
                                    end
                                    PH_R_WI: begin
                                        res_v[n_emit[0]] = mk(kcs_pkg::OP_WR_DATA, data_addr,
                                            kcs_pkg::KCS_READ_BYTE, kept_next, kcs_pkg::OC_OK);
                                        n_emit = n_emit + 2'd1;
                                        res_v[n_emit[0]] = mk(kcs_pkg::OP_RD_STATUS, cmd_addr,
                                            8'd0, kept_next, kcs_pkg::OC_OK);
                                        n_emit = n_emit + 2'd1;
                                        phase_next = PH_R_S;
                                    end
                                    default: begin
                                        res_v[n_emit[0]] = mk(kcs_pkg::OP_RD_STATUS, cmd_addr,
                                            8'd0, kept_next, kcs_pkg::OC_OK);
                                        n_emit = n_emit + 2'd1;
                                        unique case (phase_reg)
                                            PH_C_W1: phase_next = PH_C_S1;
                                            PH_C_W2: phase_next = PH_C_S2;
                                            PH_D_W:  phase_next = PH_D_S1;
                                            PH_L_W:  phase_next = PH_L_S1;
                                            default: phase_next = PH_R_S;
                                        endcase
                                    end
                                endcase
                            end else if (timer_reg >= timeout_reg) begin
                                res_v[n_emit[0]] = mk(kcs_pkg::OP_FINISHED, 16'd0, 8'd0,
                                    kept_next,
                                    (phase_reg == PH_R_W0) ? kcs_pkg::OC_IBF_TIMEOUT :
                                    (phase_reg == PH_R_WO || phase_reg == PH_R_WI) ?
                                        kcs_pkg::OC_READ_TIMEOUT : kcs_pkg::OC_SEND_FAIL);
                                n_emit = n_emit + 2'd1;
                                phase_next = PH_IDLE;
                            end else begin
                                res_v[n_emit[0]] = mk(kcs_pkg::OP_RD_STATUS, cmd_addr, 8'd0,
                                                      kept_next, kcs_pkg::OC_OK);
                                n_emit = n_emit + 2'd1;
                            end
                        end
                        PH_C_S1, PH_C_S2, PH_D_S2, PH_L_S2: begin
                            if (obf) begin
                                res_v[n_emit[0]] = mk(kcs_pkg::OP_RD_DATA, data_addr, 8'd0,
                                                      kept_next, kcs_pkg::OC_OK);
                                n_emit = n_emit + 2'd1;
                                unique case (phase_reg)
                                    PH_C_S1: phase_next = PH_C_D1;
                                    PH_C_S2: phase_next = PH_C_D2;
                                    PH_D_S2: phase_next = PH_D_D;
                                    default: phase_next = PH_L_D;
                                endcase
                            end else begin
                                do_cmd  = (phase_reg == PH_C_S1);
                                do_unit = (phase_reg == PH_C_S2) || (phase_reg == PH_D_S2);
                                do_last = (phase_reg == PH_L_S2);
                            end
                        end
                        PH_D_S1, PH_L_S1: begin
                            if (bad) begin
                                res_v[n_emit[0]] = mk(kcs_pkg::OP_FINISHED, 16'd0, 8'd0,
                                                      kept_next, kcs_pkg::OC_SEND_FAIL);
                                n_emit = n_emit + 2'd1;
                                phase_next = PH_IDLE;
                            end else begin
                                res_v[n_emit[0]] = mk(kcs_pkg::OP_RD_STATUS, cmd_addr, 8'd0,
                                                      kept_next, kcs_pkg::OC_OK);
                                n_emit = n_emit + 2'd1;
                                phase_next = (phase_reg == PH_D_S1) ? PH_D_S2 : PH_L_S2;
                            end
                        end
                        PH_R_S: begin
                            if (kst == kcs_pkg::KST_IDLE) begin
                                res_v[n_emit[0]] = mk(kcs_pkg::OP_FINISHED, 16'd0, 8'd0,
                                                      kept_next, kcs_pkg::OC_OK);
                                n_emit = n_emit + 2'd1;
                                phase_next = PH_IDLE;
                            end else if (kst != kcs_pkg::KST_READ) begin
                                res_v[n_emit[0]] = mk(kcs_pkg::OP_FINISHED, 16'd0, 8'd0,
                                                      kept_next, kcs_pkg::OC_WRONG_STATE);
                                n_emit = n_emit + 2'd1;
                                phase_next = PH_IDLE;
                            end else begin
                                timer_next = '0;
                                res_v[n_emit[0]] = mk(kcs_pkg::OP_RD_STATUS, cmd_addr, 8'd0,
                                                      kept_next, kcs_pkg::OC_OK);
                                n_emit = n_emit + 2'd1;
                                phase_next = PH_R_WO;
                            end
                        end
                        default: ;
                    endcase
                end
                kcs_pkg::REQ_DATA: begin
                    unique case (phase_reg)
                        PH_C_D1: do_cmd = 1'b1;
                        PH_C_D2, PH_D_D: do_unit = 1'b1;
                        PH_L_D: do_last = 1'b1;
                        PH_R_D: begin
                            kept_next = kept_reg + 8'd1;
                            res_v[n_emit[0]] = mk(kcs_pkg::OP_REPLY, 16'd0, s_read_data,
                                                  kept_next, kcs_pkg::OC_OK);
                            n_emit = n_emit + 2'd1;
                            timer_next = '0;
                            res_v[n_emit[0]] = mk(kcs_pkg::OP_RD_STATUS, cmd_addr, 8'd0,
                                                  kept_next, kcs_pkg::OC_OK);
                            n_emit = n_emit + 2'd1;
                            phase_next = PH_R_WI;
                        end
                        default: ;
                    endcase
                end
                kcs_pkg::REQ_TICK: begin
                    if (timer_reg != 16'hFFFF) begin
                        timer_next = timer_reg + 16'd1;
                    end
                end
                default: ;
            endcase
        end

        if (do_cmd) begin
            res_v[n_emit[0]] = mk(kcs_pkg::OP_WR_CMD, cmd_addr,
                (stage_reg == ST_START) ? kcs_pkg::KCS_START_WRITE : kcs_pkg::KCS_END_WRITE,
                kept_next, kcs_pkg::OC_OK);
            n_emit = n_emit + 2'd1;
            timer_next = '0;
            res_v[n_emit[0]] = mk(kcs_pkg::OP_RD_STATUS, cmd_addr, 8'd0, kept_next,
                                  kcs_pkg::OC_OK);
            n_emit = n_emit + 2'd1;
            phase_next = PH_C_W2;
        end

        if (do_unit) begin
            // each arm writes at most one data byte then starts a wait
            phase_next = PH_D_W;
            unique case (stage_reg)
                ST_START: begin
                    stage_next = ST_HEADER;
                    res_v[n_emit[0]] = mk(kcs_pkg::OP_WR_DATA, data_addr, header_reg,
                                          kept_next, kcs_pkg::OC_OK);
                    n_emit = n_emit + 2'd1;
                end
                ST_HEADER: begin
                    si_next = '0;
                    if (len_reg == '0) begin
                        stage_next = ST_END;
                        phase_next = PH_C_W1;
                    end else begin
                        stage_next = ST_BODY;
                        res_v[n_emit[0]] = mk(kcs_pkg::OP_WR_DATA, data_addr, command_reg,
                                              kept_next, kcs_pkg::OC_OK);
                        n_emit = n_emit + 2'd1;
                    end
                end
                ST_BODY: begin
                    si_next = si_inc;
                    if (CW'(si_inc) < CW'(len_reg)) begin
                        // the index wraps to the command byte after 255
                        res_v[n_emit[0]] = mk(kcs_pkg::OP_WR_DATA, data_addr,
                            (si_inc == 8'd0) ? command_reg : rd_data_reg,
                            kept_next, kcs_pkg::OC_OK);
                        n_emit = n_emit + 2'd1;
                    end else begin
                        stage_next = ST_END;
                        phase_next = PH_C_W1;
                    end
                end
                default: begin
                    stage_next = ST_LAST;
                    phase_next = PH_L_W;
                end
            endcase
            timer_next = '0;
            res_v[n_emit[0]] = mk(kcs_pkg::OP_RD_STATUS, cmd_addr, 8'd0, kept_next,
                                  kcs_pkg::OC_OK);
            n_emit = n_emit + 2'd1;
        end

        if (do_last) begin
            res_v[n_emit[0]] = mk(kcs_pkg::OP_WR_DATA, data_addr,
                (len_reg == '0) ? command_reg : rd_data_reg, kept_next, kcs_pkg::OC_OK);
            n_emit = n_emit + 2'd1;
            stage_next = ST_READ;
            timer_next = '0;
            res_v[n_emit[0]] = mk(kcs_pkg::OP_RD_STATUS, cmd_addr, 8'd0, kept_next,
                                  kcs_pkg::OC_OK);
            n_emit = n_emit + 2'd1;
            phase_next = PH_R_W0;
        end

        if (n_emit == 2'd1) begin
            res_v[0].last = 1'b1;
        end else if (n_emit == 2'd2) begin
            res_v[1].last = 1'b1;
        end
    end

    // prefetch the byte the next state will send
    always_comb begin
        len_m1  = CW'(len_next) - CW'(1);
        rd_addr = (stage_next == ST_BODY) ? si_next[AW-1:0] : len_m1[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            payload_mem[wr_addr] <= s_payload_byte;
        end
        if (mem_we && (wr_addr == rd_addr)) begin
            rd_data_reg <= s_payload_byte;
        end else begin
            rd_data_reg <= payload_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_base_reg <= 16'd3234;
            spacing_reg   <= 5'd1;
            timeout_reg   <= 16'd5000;
            phase_reg     <= PH_IDLE;
            stage_reg     <= ST_START;
            len_reg       <= '0;
            loaded_reg    <= '0;
            si_reg        <= '0;
            header_reg    <= '0;
            command_reg   <= '0;
            timer_reg     <= '0;
            kept_reg      <= '0;
            limit_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    kcs_pkg::CFG_PORT_BASE: port_base_reg <= cfg_wdata;
                    kcs_pkg::CFG_SPACING:   spacing_reg   <= cfg_wdata[4:0];
                    kcs_pkg::CFG_TIMEOUT:   timeout_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            phase_reg   <= phase_next;
            stage_reg   <= stage_next;
            len_reg     <= len_next;
            loaded_reg  <= loaded_next;
            si_reg      <= si_next;
            header_reg  <= header_next;
            command_reg <= command_next;
            timer_reg   <= timer_next;
            kept_reg    <= kept_next;
            limit_reg   <= limit_next;
        end
    end

    kcs_rsp_fifo u_rsp_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (s_acc ? n_emit : 2'd0),
        .push0     (res_v[0]),
        .push1     (res_v[1]),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_bus_op      = out_res.op;
    assign m_bus_address = out_res.addr;
    assign m_bus_value   = out_res.value;
    assign m_reply_count = out_res.count;
    assign m_outcome     = out_res.outcome;
    assign m_last        = out_res.last;

    a_finish_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bus_op == kcs_pkg::OP_FINISHED) |-> m_last)
        else $error("finish item not marked last");

    a_kept_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        kept_reg <= limit_reg)
        else $error("reply count beyond capacity");

    a_timer_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (timer_reg == 16'hFFFF && !s_acc) |=> timer_reg == 16'hFFFF)
        else $error("wait timer left saturation without an item");

endmodule
